// ===== src/alt_pkg.sv =====
// Package for the allocation leak tracker.
// Holds transfer payload types, command and status codes and table entry type.
// No dependencies.
package alt_pkg;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] line_key;
        logic [31:0] byte_count;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] leak_line;
        logic [31:0] leak_bytes;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic [15:0] line;
        logic [31:0] bytes;
        logic [15:0] stamp;
    } way_t;

    localparam logic [1:0] CMD_RECORD  = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_REPORT  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_FREE = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_LEAK     = 3'd3;
    localparam logic [2:0] ST_NO_LEAKS = 3'd4;

    localparam int unsigned MAX_OUT = 64;

endpackage

// ===== src/alt_newest.sv =====
// Newest-entry selector over the ways of one bucket row.
// Depends on alt_pkg.
module alt_newest #(
    parameter int unsigned WAYS  = 4,
    parameter int unsigned WAY_W = 2
) (
    input  logic [WAYS-1:0]               cand,
    input  alt_pkg::way_t [WAYS-1:0]      row,
    input  logic [15:0]                   counter,
    output logic                          found,
    output logic [WAY_W-1:0]              idx
);
    import alt_pkg::*;

    logic [15:0] best_age;
    logic [15:0] age;

    always_comb
    begin
        found    = 1'b0;
        idx      = '0;
        best_age = '0;
        age      = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            age = counter - row[w].stamp;
            if (cand[w] && (!found || age < best_age))
            begin
                found    = 1'b1;
                idx      = WAY_W'(w);
                best_age = age;
            end
        end
    end

endmodule

// ===== src/allocation_leak_tracker.sv =====
// Top level of the allocation leak tracker: bucket memory, valid flags, control.
// Depends on alt_pkg and alt_newest.
//
//  channel | signals              | direction | handshake
//  item    | start, busy, item    | in        | transfer when start and not busy
//  result  | done, result         | out       | one-cycle done per result, no stall
//
// Record, release and unused codes go through a bucket row read, then an update.
// Report scans the buckets in turn, visiting each live entry, then finishes in S_FIN.
// The bucket memory has one read and one write port; valid flags live in flops.
// Reset clears all valid flags and the insertion counter at once.
// The receiver cannot stall; each result shows for exactly one cycle.
module allocation_leak_tracker #(
    parameter int unsigned BUCKETS = 16,
    parameter int unsigned WAYS    = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  alt_pkg::item_t   item,
    output logic             busy,
    output logic             done,
    output alt_pkg::result_t result
);
    import alt_pkg::*;

    localparam int unsigned BIDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    item_t             it_reg, it_next;
    logic [BIDX_W-1:0] bkt_reg, bkt_next;
    logic [15:0]       ctr_reg, ctr_next;
    logic [WAYS-1:0]   valid_reg [BUCKETS];
    logic [WAYS-1:0]   seen_reg, seen_next;
    logic              pend_v_reg, pend_v_next;
    logic [15:0]       pend_line_reg, pend_line_next;
    logic [31:0]       pend_bytes_reg, pend_bytes_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic              done_reg, done_next;
    result_t           res_reg, res_next;

    way_t [WAYS-1:0]   mem [BUCKETS];
    way_t [WAYS-1:0]   row_reg;
    logic [BIDX_W-1:0] rd_addr;
    logic              wr_en;
    logic [WAY_W-1:0]  wr_way;
    way_t              wr_data;

    logic              set_en, clr_en, clr_all;
    logic [WAY_W-1:0]  set_way, clr_way;

    logic [BIDX_W-1:0] hi_tab [256];
    logic [BIDX_W-1:0] lo_tab [256];
    logic [BIDX_W:0]   hsum;
    logic [BIDX_W-1:0] hash;

    logic [WAYS-1:0]   row_valid, cand;
    logic [WAYS-1:0]   free_ways;
    logic [WAY_W-1:0]  free_idx;
    logic              pick_found;
    logic [WAY_W-1:0]  pick_idx;

    for (genvar g = 0; g < 256; g++)
    begin : g_tab
        assign hi_tab[g] = BIDX_W'((g * 256) % BUCKETS);
        assign lo_tab[g] = BIDX_W'(g % BUCKETS);
    end

    always_comb
    begin
        hsum = {1'b0, hi_tab[item.line_key[15:8]]} + {1'b0, lo_tab[item.line_key[7:0]]};
        if (hsum >= (BIDX_W+1)'(BUCKETS))
        begin
            hash = BIDX_W'(hsum - (BIDX_W+1)'(BUCKETS));
        end
        else
        begin
            hash = BIDX_W'(hsum);
        end
    end

    assign row_valid = valid_reg[bkt_reg];
    assign free_ways = ~row_valid;

    always_comb
    begin
        free_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (free_ways[w])
            begin
                free_idx = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        cand = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (state_reg == S_SCAN)
            begin
                cand[w] = row_valid[w] && !seen_reg[w];
            end
            else
            begin
                cand[w] = row_valid[w] && (row_reg[w].line == it_reg.line_key);
            end
        end
    end

    alt_newest #(
        .WAYS  (WAYS),
        .WAY_W (WAY_W)
    ) u_newest (
        .cand    (cand),
        .row     (row_reg),
        .counter (ctr_reg),
        .found   (pick_found),
        .idx     (pick_idx)
    );

    always_comb
    begin
        state_next      = state_reg;
        it_next         = it_reg;
        bkt_next        = bkt_reg;
        ctr_next        = ctr_reg;
        seen_next       = seen_reg;
        pend_v_next     = pend_v_reg;
        pend_line_next  = pend_line_reg;
        pend_bytes_next = pend_bytes_reg;
        cnt_next        = cnt_reg;
        done_next       = 1'b0;
        res_next        = res_reg;
        rd_addr         = bkt_reg;
        wr_en           = 1'b0;
        wr_way          = free_idx;
        wr_data         = '{line: it_reg.line_key, bytes: it_reg.byte_count, stamp: ctr_reg};
        set_en          = 1'b0;
        set_way         = free_idx;
        clr_en          = 1'b0;
        clr_way         = pick_idx;
        clr_all         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    it_next  = item;
                    bkt_next = hash;
                    rd_addr  = hash;
                    if (item.command == CMD_REPORT)
                    begin
                        bkt_next  = '0;
                        rd_addr   = '0;
                        seen_next = '0;
                        cnt_next  = '0;
                        pend_v_next = 1'b0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                done_next  = 1'b1;
                res_next   = '{status: ST_OK, leak_line: '0, leak_bytes: '0, last_result: 1'b1};
                state_next = S_IDLE;
                case (it_reg.command)
                    CMD_RECORD:
                    begin
                        if (|free_ways)
                        begin
                            wr_en    = 1'b1;
                            set_en   = 1'b1;
                            ctr_next = ctr_reg + 16'd1;
                        end
                        else
                        begin
                            res_next.status = ST_FULL;
                        end
                    end
                    CMD_RELEASE:
                    begin
                        if (pick_found)
                        begin
                            clr_en = 1'b1;
                        end
                        else
                        begin
                            res_next.status = ST_BAD_FREE;
                        end
                    end
                    default:
                    begin
                        res_next.status = ST_OK;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (pick_found)
                begin
                    seen_next[pick_idx] = 1'b1;
                    if (cnt_reg < 7'(MAX_OUT))
                    begin
                        if (pend_v_reg)
                        begin
                            done_next = 1'b1;
                            res_next  = '{status: ST_LEAK, leak_line: pend_line_reg,
                                          leak_bytes: pend_bytes_reg, last_result: 1'b0};
                        end
                        pend_v_next     = 1'b1;
                        pend_line_next  = row_reg[pick_idx].line;
                        pend_bytes_next = row_reg[pick_idx].bytes;
                        cnt_next        = cnt_reg + 7'd1;
                    end
                end
                else if (bkt_reg == BIDX_W'(BUCKETS - 1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    bkt_next  = bkt_reg + 1'b1;
                    rd_addr   = bkt_reg + 1'b1;
                    seen_next = '0;
                end
            end
            S_FIN:
            begin
                done_next = 1'b1;
                if (pend_v_reg)
                begin
                    res_next = '{status: ST_LEAK, leak_line: pend_line_reg,
                                 leak_bytes: pend_bytes_reg, last_result: 1'b1};
                end
                else
                begin
                    res_next = '{status: ST_NO_LEAKS, leak_line: '0, leak_bytes: '0,
                                 last_result: 1'b1};
                end
                clr_all     = 1'b1;
                ctr_next    = '0;
                pend_v_next = 1'b0;
                cnt_next    = '0;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        row_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[bkt_reg][wr_way] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < BUCKETS; b++)
            begin
                valid_reg[b] <= '0;
            end
        end
        else if (clr_all)
        begin
            for (int b = 0; b < BUCKETS; b++)
            begin
                valid_reg[b] <= '0;
            end
        end
        else if (set_en)
        begin
            valid_reg[bkt_reg][set_way] <= 1'b1;
        end
        else if (clr_en)
        begin
            valid_reg[bkt_reg][clr_way] <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ctr_reg    <= '0;
            seen_reg   <= '0;
            pend_v_reg <= 1'b0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            bkt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ctr_reg    <= ctr_next;
            seen_reg   <= seen_next;
            pend_v_reg <= pend_v_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
            bkt_reg    <= bkt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg         <= it_next;
        pend_line_reg  <= pend_line_next;
        pend_bytes_reg <= pend_bytes_next;
        res_reg        <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_reg.last_result |-> state_reg == S_IDLE)
        else $error("final result seen while still working");

    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 7'(MAX_OUT))
        else $error("report result count over limit");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("transfer accepted without going busy");

    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN |=> ctr_reg == 16'd0 && !pend_v_reg)
        else $error("report did not clear the table state");

endmodule
